>>> hw/rtl/uvld_pkg.sv
// Shared types, register indexes and helpers for the undervoltage level detector.
// No dependencies; every other file of the block depends on this package.
package uvld_pkg;

	// Detector level, as reported on the result channel
	typedef enum logic [1:0] {
		LVL_NORMAL   = 2'd0,
		LVL_FIRST    = 2'd1,
		LVL_SECOND   = 2'd2,
		LVL_RETURNED = 2'd3
	} level_t;

	// Configuration register indexes
	localparam int unsigned CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_ENABLE     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_THR_RETURN = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_THR_FIRST  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_THR_SECOND = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_DET_COUNT  = 3'd4;

	localparam int unsigned CfgDataW = 8;
	localparam int unsigned MvW      = 16;
	localparam int unsigned CntW     = 8;
	localparam int unsigned LimW     = 15;  // 255 * 100 fits in 15 bits

	// Register reset values
	localparam logic [7:0] THR_RETURN_RST = 8'd75;
	localparam logic [7:0] THR_FIRST_RST  = 8'd70;
	localparam logic [7:0] THR_SECOND_RST = 8'd65;
	localparam logic [7:0] DET_COUNT_RST  = 8'd3;

	// Configuration seen by the step logic
	typedef struct packed {
		logic            enable;
		logic [7:0]      thr_return;
		logic [7:0]      thr_first;
		logic [7:0]      thr_second;
		logic [CntW-1:0] persist_lim;
	} det_cfg_t;

	// Detector state carried from beat to beat
	typedef struct packed {
		level_t          level;
		logic [CntW-1:0] cnt_second;
		logic [CntW-1:0] cnt_first;
		logic [CntW-1:0] cnt_recovery;
	} det_state_t;

	// Per-beat result
	typedef struct packed {
		level_t level;
		logic   anomaly;
	} det_result_t;

	// Threshold in tenths of a volt to millivolts: t*100 = t*64 + t*32 + t*4
	function automatic logic [LimW-1:0] mv_limit(input logic [7:0] tenths);
		logic [LimW-1:0] w;
		w = {{(LimW-8){1'b0}}, tenths};
		return (w << 6) + (w << 5) + (w << 2);
	endfunction

endpackage

>>> hw/rtl/uvld_if.sv
// Valid/ready channel interfaces for voltage samples and level results.
// Depends on uvld_pkg for the sample width and the level type.
interface uvld_in_if;
	logic                       valid;
	logic                       ready;
	logic [uvld_pkg::MvW-1:0]   battery_millivolts;

	modport source (output valid, output battery_millivolts, input ready);
	modport sink   (input valid, input battery_millivolts, output ready);
endinterface

interface uvld_out_if;
	logic             valid;
	logic             ready;
	uvld_pkg::level_t current_level;
	logic             anomaly_event;

	modport source (output valid, output current_level, output anomaly_event, input ready);
	modport sink   (input valid, input current_level, input anomaly_event, output ready);
endinterface

>>> hw/rtl/uvld_step.sv
// Next-state logic of the detector: threshold compares, counters and level moves.
// Purely combinational; depends on uvld_pkg.
module uvld_step (
	input  logic [uvld_pkg::MvW-1:0] mv,
	input  uvld_pkg::det_cfg_t       cfg,
	input  uvld_pkg::det_state_t     cur,
	output uvld_pkg::det_state_t     nxt,
	output uvld_pkg::det_result_t    res
);
	import uvld_pkg::*;

	logic [MvW-1:0] lim_ret, lim_one, lim_two;
	logic           low_level;
	logic           mv_below_two, mv_below_one, mv_above_ret;

	// Thresholds scaled to millivolts
	assign lim_ret = {1'b0, mv_limit(cfg.thr_return)};
	assign lim_one = {1'b0, mv_limit(cfg.thr_first)};
	assign lim_two = {1'b0, mv_limit(cfg.thr_second)};

	assign low_level    = (cur.level == LVL_FIRST) || (cur.level == LVL_SECOND);
	assign mv_below_two = mv < lim_two;
	assign mv_below_one = mv < lim_one;
	assign mv_above_ret = mv > lim_ret;

	// Saturating bump
	function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	// Level moves in priority order; a move fires when its counter already
	// exceeds the detect count
	always_comb begin
		nxt = cur;
		if (cfg.enable) begin
			if (mv_below_two && (cur.level == LVL_FIRST)) begin
				nxt.cnt_second = bump(cur.cnt_second);
				if (cur.cnt_second > cfg.persist_lim) nxt.level = LVL_SECOND;
			end else if (mv_below_one && !low_level) begin
				nxt.cnt_first = bump(cur.cnt_first);
				if (cur.cnt_first > cfg.persist_lim) nxt.level = LVL_FIRST;
			end else if (mv_above_ret && low_level) begin
				nxt.cnt_recovery = bump(cur.cnt_recovery);
				if (cur.cnt_recovery > cfg.persist_lim) nxt.level = LVL_RETURNED;
			end else begin
				nxt.cnt_second   = '0;
				nxt.cnt_first    = '0;
				nxt.cnt_recovery = '0;
			end
		end
	end

	assign res.level   = nxt.level;
	assign res.anomaly = nxt.level != cur.level;

endmodule

>>> hw/rtl/undervoltage_level_detector.sv
// Battery undervoltage level detector, top level: config registers, sample
// stage, detector state and result register. Depends on uvld_pkg, uvld_if, uvld_step.
//
// Takes one millivolt sample per beat on bat_in and returns one beat on lvl_out
// with the level after that sample and a flag when the level changed. One
// sample can be accepted every cycle while lvl_out is not stalled; an input beat
// passes the sample register, then the result register, with the
// single compare-and-update pass running between them. The result register
// decouples the sides, so a new sample is taken while a result waits. Thresholds
// are in tenths of a volt, compared as threshold*100 mV; software keeps
// return >= first >= second > 0. Writing the enable register also returns the
// level to normal; write configuration only while no beat is in flight.
module undervoltage_level_detector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [uvld_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [uvld_pkg::CfgDataW-1:0]  cfg_wdata,
	uvld_in_if.sink                        bat_in,
	uvld_out_if.source                     lvl_out
);
	import uvld_pkg::*;

	det_cfg_t    cfg_q;
	det_state_t  state_q, state_nxt;
	det_result_t step_res;

	logic           valid_s1;
	logic [MvW-1:0] mv_s1;
	logic           adv_s1;

	logic   out_valid_q;
	level_t out_level_q;
	logic   out_anom_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable      <= 1'b0;
			cfg_q.thr_return  <= THR_RETURN_RST;
			cfg_q.thr_first   <= THR_FIRST_RST;
			cfg_q.thr_second  <= THR_SECOND_RST;
			cfg_q.persist_lim <= DET_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:     cfg_q.enable      <= cfg_wdata[0];
				REG_THR_RETURN: cfg_q.thr_return  <= cfg_wdata;
				REG_THR_FIRST:  cfg_q.thr_first   <= cfg_wdata;
				REG_THR_SECOND: cfg_q.thr_second  <= cfg_wdata;
				REG_DET_COUNT:  cfg_q.persist_lim <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sample stage moves on when the result register is free or drains
	assign adv_s1       = valid_s1 && (!out_valid_q || lvl_out.ready);
	assign bat_in.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bat_in.ready) begin
			valid_s1 <= bat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bat_in.valid && bat_in.ready) mv_s1 <= bat_in.battery_millivolts;
	end

	uvld_step u_step (
		.mv  (mv_s1),
		.cfg (cfg_q),
		.cur (state_q),
		.nxt (state_nxt),
		.res (step_res)
	);

	// Detector state; an enable write forces the level back to normal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{level: LVL_NORMAL, cnt_second: '0, cnt_first: '0,
				cnt_recovery: '0};
		end else if (cfg_we && (cfg_index == REG_ENABLE)) begin
			state_q.level <= LVL_NORMAL;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || lvl_out.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_level_q <= step_res.level;
			out_anom_q  <= step_res.anomaly;
		end
	end

	assign lvl_out.valid         = out_valid_q;
	assign lvl_out.current_level = out_level_q;
	assign lvl_out.anomaly_event = out_anom_q;

	// A disabled detector never reports a level change
	a_no_anom_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && step_res.anomaly) |-> cfg_q.enable)
		else $error("level change computed while detector disabled");

	// The level moves only on a sample beat or an enable write
	a_level_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.level != $past(state_q.level)) |->
		$past(adv_s1 || (cfg_we && (cfg_index == REG_ENABLE))))
		else $error("level changed without a sample beat or enable write");

	// A reported change is really taken into the state
	a_anom_commits: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && step_res.anomaly && !cfg_we) |=>
		(state_q.level != $past(state_q.level)))
		else $error("reported level change not committed");

endmodule
